>>> rtl/core/qte_pkg.sv
package qte_pkg;

    localparam int XW  = 34;  // cordic vector width
    localparam int SQW = 62;  // square root work width
    localparam int SQ_STEPS = 31;

    typedef struct packed {
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic [31:0]          z;
    } vec_t;

    typedef struct packed {
        logic [SQW-1:0] n;
        logic [SQW-1:0] r;
    } sq_t;

    // round(atan(2^-i) * 2^32 / (2 pi))
    function automatic logic [31:0] atan_step(input int i);
        logic [31:0] v;
        case (i)
            0:  v = 32'd536870912;
            1:  v = 32'd316933406;
            2:  v = 32'd167458907;
            3:  v = 32'd85004756;
            4:  v = 32'd42667331;
            5:  v = 32'd21354465;
            6:  v = 32'd10679838;
            7:  v = 32'd5340245;
            8:  v = 32'd2670163;
            9:  v = 32'd1335087;
            10: v = 32'd667544;
            11: v = 32'd333772;
            12: v = 32'd166886;
            13: v = 32'd83443;
            14: v = 32'd41722;
            15: v = 32'd20861;
            16: v = 32'd10430;
            17: v = 32'd5215;
            18: v = 32'd2608;
            19: v = 32'd1304;
            20: v = 32'd652;
            21: v = 32'd326;
            22: v = 32'd163;
            23: v = 32'd81;
            24: v = 32'd41;
            25: v = 32'd20;
            26: v = 32'd10;
            27: v = 32'd5;
            28: v = 32'd3;
            29: v = 32'd1;
            30: v = 32'd1;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

>>> rtl/core/qte_sqrt_cell.sv
module qte_sqrt_cell import qte_pkg::*; #(
    parameter int K = 0
) (
    input  logic aclk,
    input  logic ce,
    input  sq_t  d_in,
    output sq_t  d_reg
);

    localparam logic [SQW-1:0] BIT = SQW'(1) << (2 * K);

    sq_t            d_next;
    logic [SQW-1:0] trial;

    always_comb begin
        trial = d_in.r + BIT;
        if (d_in.n >= trial) begin
            d_next.n = d_in.n - trial;
            d_next.r = (d_in.r >> 1) + BIT;
        end else begin
            d_next.n = d_in.n;
            d_next.r = d_in.r >> 1;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            d_reg <= d_next;
        end
    end

endmodule

>>> rtl/core/qte_prep.sv
module qte_prep import qte_pkg::*; #(
    parameter int TW = 36
) (
    input  logic                 aclk,
    input  logic                 ce,
    input  logic signed [TW-1:0] x_in,
    input  logic signed [TW-1:0] y_in,
    output vec_t                 v_reg
);

    localparam int LW = $clog2(TW + 2);
    localparam logic [LW-1:0] NORM = LW'(30);

    logic signed [TW:0] xa, ya, xa_reg, ya_reg;
    logic [TW:0]        ym, m;
    logic [LW-1:0]      len, len_reg;
    logic               neg_reg;
    logic signed [TW:0] xs, ys;
    vec_t               v_next;

    // fold into the right half plane, then find the magnitude bit length
    always_comb begin
        if (x_in < 0) begin
            xa = -(TW+1)'(x_in);
            ya = -(TW+1)'(y_in);
        end else begin
            xa = (TW+1)'(x_in);
            ya = (TW+1)'(y_in);
        end
        ym = (ya < 0) ? unsigned'(-ya) : unsigned'(ya);
        m  = (unsigned'(xa) > ym) ? unsigned'(xa) : ym;
        len = '0;
        for (int b = 0; b <= TW; b++) begin
            if (m[b]) begin
                len = LW'(b + 1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            xa_reg  <= xa;
            ya_reg  <= ya;
            len_reg <= len;
            neg_reg <= x_in < 0;
        end
    end

    always_comb begin
        if (len_reg > NORM) begin
            xs = xa_reg >>> (len_reg - NORM);
            ys = ya_reg >>> (len_reg - NORM);
        end else begin
            xs = xa_reg <<< (NORM - len_reg);
            ys = ya_reg <<< (NORM - len_reg);
        end
        v_next.x = XW'(xs);
        v_next.y = XW'(ys);
        v_next.z = neg_reg ? 32'h8000_0000 : 32'h0;
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            v_reg <= v_next;
        end
    end

endmodule

>>> rtl/core/qte_cordic_cell.sv
module qte_cordic_cell import qte_pkg::*; #(
    parameter int STAGE = 0
) (
    input  logic aclk,
    input  logic ce,
    input  vec_t v_in,
    output vec_t v_reg
);

    localparam logic [31:0] STEP = atan_step(STAGE);

    logic signed [XW-1:0] dx, dy;
    vec_t                 v_next;

    always_comb begin
        dx = v_in.y >>> STAGE;
        dy = v_in.x >>> STAGE;
        v_next = v_in;
        // a vector already on the axis stays put
        if (v_in.y > 0) begin
            v_next.x = v_in.x + dx;
            v_next.y = v_in.y - dy;
            v_next.z = v_in.z + STEP;
        end else if (v_in.y < 0) begin
            v_next.x = v_in.x - dx;
            v_next.y = v_in.y + dy;
            v_next.z = v_in.z - STEP;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            v_reg <= v_next;
        end
    end

endmodule

>>> rtl/core/quaternion_to_euler_angles.sv
// Quaternion (w, x, y, z, signed Q2.14 by default) to ZYX Euler angles: roll,
// pitch and yaw as signed 16-bit binary angles (32768 = pi). Fully pipelined:
// one quaternion per clock unless the output stalls. The pipeline holds 4 arithmetic
// stages, 31 stages of the pitch square root, 2 normalize stages, one
// CORDIC cell per stage and one output register. The whole chain advances
// together and fills bubbles while a result waits on m_tready.
module quaternion_to_euler_angles import qte_pkg::*; #(
    parameter int ANGLE_BITS     = 16,
    parameter int QUAT_FRAC_BITS = 14,
    parameter int CORDIC_STAGES  = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // quat_w, quat_x, quat_y, quat_z
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata    // roll_angle, pitch_angle, yaw_angle
);

    localparam int F   = QUAT_FRAC_BITS;
    localparam int TW  = (2 * F + 3 > 36) ? 2 * F + 3 : 36;
    localparam int SHR = (2 * F > 30) ? 2 * F - 30 : 0;
    localparam int SHL = (2 * F < 30) ? 30 - 2 * F : 0;
    localparam int DLY = 2 + SQ_STEPS;
    localparam int L   = 4 + SQ_STEPS + 2 + CORDIC_STAGES;
    localparam int SH  = 32 - ANGLE_BITS;
    localparam logic [32:0] HALF = (SH > 0) ? (33'(1) << ((SH > 0) ? SH - 1 : 0)) : 33'(0);
    localparam logic signed [TW-1:0] ONE = TW'(1) << (2 * F);

    typedef struct packed {
        logic signed [31:0] wx, yz, xx, yy, wy, zx, wz, xy, zz;
    } prod_t;

    typedef struct packed {
        logic signed [TW-1:0] t0, t1, t3, t4;
        logic signed [31:0]   s;
    } term_t;

    logic               ce, last_valid;
    logic [L-1:0]       vld_reg;
    logic signed [15:0] qw, qx, qy, qz;
    prod_t              prod_reg;
    term_t              term_reg, term_next;
    term_t              dly_reg [DLY];
    logic signed [TW-1:0] t2, t2c;
    logic signed [63:0] ss_reg;
    sq_t                sq_in_reg;
    sq_t                sq_chain [SQ_STEPS+1];
    vec_t               roll_chain  [CORDIC_STAGES+1];
    vec_t               pitch_chain [CORDIC_STAGES+1];
    vec_t               yaw_chain   [CORDIC_STAGES+1];
    logic               m_tvalid_reg;
    logic [47:0]        m_tdata_reg;

    function automatic logic [15:0] angle_out(input logic [31:0] z);
        logic [32:0]                v;
        logic signed [ANGLE_BITS-1:0] a;
        v = ({1'b0, z} + HALF) >> SH;
        a = signed'(v[ANGLE_BITS-1:0]);
        return 16'(32'(a));
    endfunction

    assign last_valid = vld_reg[L-1];
    assign ce         = !m_tvalid_reg || m_tready || !last_valid;
    assign s_tready   = ce;
    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;

    assign qw = signed'(s_tdata[15:0]);
    assign qx = signed'(s_tdata[31:16]);
    assign qy = signed'(s_tdata[47:32]);
    assign qz = signed'(s_tdata[63:48]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (ce) begin
            vld_reg <= {vld_reg[L-2:0], s_tvalid};
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            prod_reg.wx <= qw * qx;
            prod_reg.yz <= qy * qz;
            prod_reg.xx <= qx * qx;
            prod_reg.yy <= qy * qy;
            prod_reg.wy <= qw * qy;
            prod_reg.zx <= qz * qx;
            prod_reg.wz <= qw * qz;
            prod_reg.xy <= qx * qy;
            prod_reg.zz <= qz * qz;
        end
    end

    always_comb begin
        term_next.t0 = (TW'(prod_reg.wx) + TW'(prod_reg.yz)) <<< 1;
        term_next.t1 = ONE - ((TW'(prod_reg.xx) + TW'(prod_reg.yy)) <<< 1);
        term_next.t3 = (TW'(prod_reg.wz) + TW'(prod_reg.xy)) <<< 1;
        term_next.t4 = ONE - ((TW'(prod_reg.yy) + TW'(prod_reg.zz)) <<< 1);
        t2 = (TW'(prod_reg.wy) - TW'(prod_reg.zx)) <<< 1;
        // pitch argument clamped to [-1, 1], then rescaled to 2^30 = 1.0
        if (t2 > ONE) begin
            t2c = ONE;
        end else if (t2 < -ONE) begin
            t2c = -ONE;
        end else begin
            t2c = t2;
        end
        term_next.s = 32'((t2c >>> SHR) <<< SHL);
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            term_reg  <= term_next;
            ss_reg    <= term_reg.s * term_reg.s;
            sq_in_reg <= '{n: (SQW'(1) << 60) - SQW'(ss_reg), r: '0};
            dly_reg[0] <= term_reg;
            for (int j = 1; j < DLY; j++) begin
                dly_reg[j] <= dly_reg[j-1];
            end
        end
    end

    assign sq_chain[0] = sq_in_reg;

    for (genvar j = 0; j < SQ_STEPS; j++) begin : g_sqrt
        qte_sqrt_cell #(.K(SQ_STEPS - 1 - j)) u_cell (
            .aclk  (aclk),
            .ce    (ce),
            .d_in  (sq_chain[j]),
            .d_reg (sq_chain[j+1])
        );
    end

    qte_prep #(.TW(TW)) u_prep_roll (
        .aclk (aclk), .ce (ce),
        .x_in (dly_reg[DLY-1].t1), .y_in (dly_reg[DLY-1].t0),
        .v_reg (roll_chain[0])
    );

    qte_prep #(.TW(32)) u_prep_pitch (
        .aclk (aclk), .ce (ce),
        .x_in (signed'(sq_chain[SQ_STEPS].r[31:0])), .y_in (dly_reg[DLY-1].s),
        .v_reg (pitch_chain[0])
    );

    qte_prep #(.TW(TW)) u_prep_yaw (
        .aclk (aclk), .ce (ce),
        .x_in (dly_reg[DLY-1].t4), .y_in (dly_reg[DLY-1].t3),
        .v_reg (yaw_chain[0])
    );

    for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
        qte_cordic_cell #(.STAGE(i)) u_roll (
            .aclk (aclk), .ce (ce), .v_in (roll_chain[i]), .v_reg (roll_chain[i+1])
        );
        qte_cordic_cell #(.STAGE(i)) u_pitch (
            .aclk (aclk), .ce (ce), .v_in (pitch_chain[i]), .v_reg (pitch_chain[i+1])
        );
        qte_cordic_cell #(.STAGE(i)) u_yaw (
            .aclk (aclk), .ce (ce), .v_in (yaw_chain[i]), .v_reg (yaw_chain[i+1])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (m_tready || !m_tvalid_reg) begin
            m_tvalid_reg <= last_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if ((m_tready || !m_tvalid_reg) && last_valid) begin
            m_tdata_reg <= {angle_out(yaw_chain[CORDIC_STAGES].z),
                            angle_out(pitch_chain[CORDIC_STAGES].z),
                            angle_out(roll_chain[CORDIC_STAGES].z)};
        end
    end

    a_stall_only_on_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (m_tvalid && !m_tready && last_valid))
        else $error("input stalled without a waiting result");

    a_accept_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> vld_reg[0])
        else $error("accepted beat not tracked");

    a_no_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        (last_valid && m_tvalid && !m_tready) |=> (last_valid && m_tvalid))
        else $error("finished beat dropped during stall");

endmodule
